>>> rtl/esc_telemetry_frame_decoder_defines.svh
// assertion macros for the esc telemetry frame decoder checker
// no dependencies; included by files that carry concurrent assertions
`ifndef ESC_TELEMETRY_FRAME_DECODER_DEFINES_SVH
`define ESC_TELEMETRY_FRAME_DECODER_DEFINES_SVH

// property checked only while out of reset
`define ETD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define ETD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/etd_pkg.sv
// shared types, constants and the crc-8 step for the esc telemetry frame decoder
// no dependencies
`default_nettype none

package etd_pkg;

    localparam int FRAME_BYTES   = 10;
    localparam int BODY_BYTES    = 9;
    localparam int COUNT_W       = 4;
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_TOP  = 8'h80;
    localparam int ERPM_SCALE    = 100;
    localparam int ERPM_W        = 23;
    localparam logic [15:0] TIMEOUT_RESET = 16'd350;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam int RESULT_W = 8 + 16 + 16 + 16 + ERPM_W;
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_TICK = 1'b1
    } etd_kind_t;

    typedef struct packed {
        etd_kind_t  kind;
        logic [7:0] data;
    } etd_item_t;

    // head of the queue as seen by the back end
    typedef struct packed {
        logic      valid;
        etd_item_t item;
    } etd_head_t;

    typedef struct packed {
        logic [ERPM_W-1:0] electrical_rpm;
        logic [15:0]       consumption_mah;
        logic [15:0]       current_centiamps;
        logic [15:0]       voltage_centivolts;
        logic signed [7:0] temperature_c;
    } etd_result_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if ((v & CRC_TOP) != 8'd0) begin
                v = (v << 1) ^ CRC_POLY;
            end else begin
                v = v << 1;
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/etd_front.sv
// front end: registers and classifies incoming words, pushes them into the queue
// depends on etd_pkg
`default_nettype none

module etd_front (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_tvalid,
    output logic               s_tready,
    input  wire  [7:0]         s_tdata,
    input  wire                s_tuser,
    input  wire                q_full,
    output logic               q_push,
    output etd_pkg::etd_item_t q_item
);
    import etd_pkg::*;

    logic      valid_reg, valid_next;
    etd_item_t item_reg, item_next;
    etd_kind_t kind;

    always_comb begin
        unique case (s_tuser)
            1'b1:    kind = KIND_TICK;
            default: kind = KIND_BYTE;
        endcase
    end

    assign q_push   = valid_reg && !q_full;
    assign q_item   = item_reg;
    assign s_tready = !valid_reg || q_push;

    always_comb begin
        valid_next = valid_reg && !q_push;
        item_next  = item_reg;
        if (s_tvalid && s_tready) begin
            valid_next     = 1'b1;
            item_next.kind = kind;
            // byte value is meaningless for ticks, keep it anyway
            item_next.data = s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

>>> rtl/etd_queue.sv
// short queue between front and back end
// depends on etd_pkg
`default_nettype none

module etd_queue (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                push,
    input  etd_pkg::etd_item_t push_item,
    output logic               full,
    input  wire                pop,
    output etd_pkg::etd_head_t head
);
    import etd_pkg::*;

    etd_item_t        mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]     count_reg, count_next;
    logic             do_pop;

    assign full       = (count_reg == (QAW+1)'(QDEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/etd_back.sv
// back end: frame assembly, crc check, gap timeout and the result register
// depends on etd_pkg
`default_nettype none

module etd_back (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_wr_en,
    input  wire  [15:0]          cfg_wr_data,
    input  etd_pkg::etd_head_t   head,
    output logic                 pop,
    output logic                 out_valid,
    input  wire                  out_ready,
    output etd_pkg::etd_result_t out_result
);
    import etd_pkg::*;

    logic [7:0]          store_reg [BODY_BYTES];
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [7:0]          crc_reg, crc_next;
    logic [15:0]         pending_reg, pending_next;
    logic [15:0]         timeout_reg;
    logic                out_valid_reg, out_valid_next;
    etd_result_t         result_reg, result_next;

    logic [15:0]         limit;
    logic [16:0]         pending_inc;
    logic                store_en;
    logic                emit;
    logic [15:0]         rpm_raw;

    // consume the next word whenever the result slot can take a result
    assign pop        = head.valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    assign limit       = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
    assign pending_inc = {1'b0, pending_reg} + 17'd1;
    assign rpm_raw     = {store_reg[7], store_reg[8]};

    always_comb begin
        count_next   = count_reg;
        crc_next     = crc_reg;
        pending_next = pending_reg;
        store_en     = 1'b0;
        emit         = 1'b0;
        if (pop) begin
            unique case (head.item.kind)
                KIND_TICK: begin
                    if (count_reg != '0) begin
                        if (pending_inc >= {1'b0, limit}) begin
                            count_next   = '0;
                            crc_next     = '0;
                            pending_next = '0;
                        end else begin
                            pending_next = pending_inc[15:0];
                        end
                    end
                end
                KIND_BYTE: begin
                    if (count_reg < COUNT_W'(BODY_BYTES)) begin
                        store_en     = 1'b1;
                        crc_next     = crc8_step(crc_reg, head.item.data);
                        count_next   = count_reg + 1'b1;
                        pending_next = '0;
                    end else begin
                        // tenth byte closes the frame either way
                        emit         = (head.item.data == crc_reg);
                        count_next   = '0;
                        crc_next     = '0;
                        pending_next = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !out_ready;
        result_next    = result_reg;
        if (emit) begin
            out_valid_next                 = 1'b1;
            result_next.temperature_c      = store_reg[0];
            result_next.voltage_centivolts = {store_reg[1], store_reg[2]};
            result_next.current_centiamps  = {store_reg[3], store_reg[4]};
            result_next.consumption_mah    = {store_reg[5], store_reg[6]};
            result_next.electrical_rpm     = ERPM_W'(rpm_raw) * ERPM_W'(ERPM_SCALE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            crc_reg       <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
            timeout_reg   <= TIMEOUT_RESET;
        end else begin
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
        end
        result_reg <= result_next;
    end

    always_ff @(posedge aclk) begin
        if (store_en) begin
            store_reg[count_reg] <= head.item.data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/esc_telemetry_frame_decoder.sv
// esc telemetry frame decoder top level: crc-8 checked 10-byte frames to fields
// depends on etd_pkg, etd_front, etd_queue, etd_back
//
// usage:
//   input channel s_*: one word per received uart byte (s_tuser = 0, byte in
//   s_tdata) or per timer tick (s_tuser = 1). one word per cycle is taken while s_tready is high.
//   output channel m_*: one word per frame whose tenth byte matches the crc-8
//   (poly 0x07, seed 0) of its first nine bytes; bad frames vanish silently.
//   cfg_wr_en/cfg_wr_data set the gap timeout in ticks (reset value 350); a
//   partial frame idle that long since its last byte is thrown away.
// path: the tenth byte passes through the front register and a queue entry to
//   the back end result register, which drives m_tvalid.
// throughput: one word per cycle unless a stalled result holds the back end,
//   set by its combinational crc step and its pop from the four-entry queue.
// stall: while m_tvalid is high and m_tready low the result holds and the back
//   end stops popping; the queue and front register hold up to five words,
//   then s_tready drops.
// reset: synchronous, active low; clears frame progress, crc, tick count,
//   queue and output valid, and restores the timeout to 350.
`default_nettype none

module esc_telemetry_frame_decoder (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_wr_en,
    input  wire  [15:0]                  cfg_wr_data,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [7:0]                   s_tdata,   // [7:0] rx_byte
    input  wire                          s_tuser,   // [0] opcode
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // [7:0] temperature_c, [23:8] voltage_centivolts, [39:24] current_centiamps,
    // [55:40] consumption_mah, [78:56] electrical_rpm, [79] zero
    output logic [etd_pkg::TDATA_W-1:0]  m_tdata
);
    import etd_pkg::*;

    logic        q_full;
    logic        q_push;
    etd_item_t   q_item;
    logic        q_pop;
    etd_head_t   q_head;
    etd_result_t result;

    etd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    etd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head)
    );

    etd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head        (q_head),
        .pop         (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (result)
    );

    assign m_tdata = TDATA_W'(result);

endmodule

`default_nettype wire

>>> rtl/etd_checker.sv
// port-level checker for the esc telemetry frame decoder, bound to the top level
// depends on esc_telemetry_frame_decoder_defines.svh and etd_pkg
`default_nettype none

`include "esc_telemetry_frame_decoder_defines.svh"

module etd_checker (
    input wire                         aclk,
    input wire                         aresetn,
    input wire                         s_tready,
    input wire                         m_tvalid,
    input wire                         m_tready,
    input wire [etd_pkg::TDATA_W-1:0]  m_tdata
);
    import etd_pkg::*;

    // stalled result holds
    `ETD_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // reset empties the result slot and opens the input
    `ETD_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> !m_tvalid && s_tready, "reset did not clear the channels")

    // scaled erpm never exceeds 65535 * 100
    `ETD_ASSERT(a_rpm_range, aclk, aresetn, m_tvalid |-> m_tdata[78:56] <= 23'd6553500, "erpm out of range")

    // pad bit above the last field stays zero
    `ETD_ASSERT(a_pad_zero, aclk, aresetn, m_tvalid |-> m_tdata[TDATA_W-1] == 1'b0, "pad bit set")

endmodule

bind esc_telemetry_frame_decoder etd_checker u_etd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
